/* hw/rtl/stq_pkg.sv */
// ---------------------------------------------------------------------------
// Sorted timer queue package
// Item types, controller/datapath interface types, codes and helpers.
// ---------------------------------------------------------------------------
package stq_pkg;

   localparam int TIME_BITS = 32;
   localparam int ID_BITS   = 4;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_CHANGE = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   localparam logic [1:0] KIND_ABSOLUTE = 2'd0;
   localparam logic [1:0] KIND_RELATIVE = 2'd1;
   localparam logic [1:0] KIND_PERIODIC = 2'd2;

   localparam logic [1:0] EV_ACK     = 2'd0;
   localparam logic [1:0] EV_EXPIRED = 2'd1;
   localparam logic [1:0] EV_NONE    = 2'd2;
   localparam logic [1:0] EV_ERROR   = 2'd3;

   typedef struct packed {
      logic [1:0]           command;
      logic [ID_BITS-1:0]   timer_id;
      logic [1:0]           timer_kind;
      logic [TIME_BITS-1:0] time_value;
      logic [TIME_BITS-1:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [ID_BITS-1:0] event_timer;
      logic               retired;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INSERT,
      ST_TICK_HEAD,
      ST_TICK_POP
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       mark;
      logic       insert;
      logic       remove;
      logic       pop;
      logic       set_act;
      logic       clr_act;
      logic       mem_wr;
      logic       load_req;
      logic       load_per;
      logic       head_sel;
      logic       emit;
      logic [1:0] emit_kind;
      logic       emit_retired;
      logic       emit_last;
   } ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       is_tick;
      logic       err;
      logic       head_due;
      logic       next_due;
      logic       periodic;
   } sts_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
   endfunction

endpackage

/* hw/rtl/stq_datapath.sv */
// ---------------------------------------------------------------------------
// Sorted timer queue datapath
// Sorted cell list, slot tables, expiry adder and result register.
// ---------------------------------------------------------------------------
module stq_datapath import stq_pkg::*; #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_item,
   input  ctl_type ctl,
   output sts_type sts,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

   req_type              req_ff;
   logic [SLOT_W-1:0]    cur_slot_ff;
   logic [TIME_BITS-1:0] exp_ff;
   logic [1:0]           rd_kind_ff;
   logic [TIME_BITS-1:0] rd_period_ff;
   logic [TIMER_SLOTS-1:0] active_ff;

   logic [1:0]           kind_mem   [TIMER_SLOTS];
   logic [TIME_BITS-1:0] period_mem [TIMER_SLOTS];

   logic [SLOT_W-1:0]      cell_slot_ff [TIMER_SLOTS];
   logic [TIME_BITS-1:0]   cell_exp_ff  [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] cell_vld_ff;
   logic [TIMER_SLOTS-1:0] cell_due_ff;
   logic [SLOT_W-1:0]      cell_slot_in [TIMER_SLOTS];
   logic [TIME_BITS-1:0]   cell_exp_in  [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] cell_vld_in;
   logic [TIMER_SLOTS-1:0] cell_due_in;

   logic [TIMER_SLOTS-1:0] goes;
   logic [TIMER_SLOTS-1:0] match;
   logic [TIMER_SLOTS-1:0] after;

   logic [SLOT_W+ID_BITS-1:0] port_ext;
   logic [SLOT_W+ID_BITS-1:0] cur_ext;
   logic [SLOT_W-1:0]         port_slot;
   logic [SLOT_W-1:0]         rd_addr;
   logic                      id_ok;
   logic                      act;

   logic    rsp_strobe_ff;
   rsp_type rsp_item_ff;

   assign port_ext  = {{SLOT_W{1'b0}}, req_item.timer_id};
   assign port_slot = port_ext[SLOT_W-1:0];
   assign cur_ext   = {{ID_BITS{1'b0}}, cur_slot_ff};
   assign rd_addr   = ctl.head_sel ? cell_slot_ff[0] : port_slot;

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         req_ff <= req_item;
      end
      if (ctl.latch) begin
         cur_slot_ff <= port_slot;
      end else if (ctl.head_sel) begin
         cur_slot_ff <= cell_slot_ff[0];
      end
      if (ctl.load_req) begin
         exp_ff <= (req_ff.timer_kind == KIND_ABSOLUTE) ? req_ff.time_value
                   : sat_add(req_ff.now, req_ff.time_value);
      end else if (ctl.load_per) begin
         exp_ff <= sat_add(req_ff.now, rd_period_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) begin
         kind_mem[cur_slot_ff]   <= req_ff.timer_kind;
         period_mem[cur_slot_ff] <= req_ff.time_value;
      end
      rd_kind_ff   <= kind_mem[rd_addr];
      rd_period_ff <= period_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (ctl.set_act) begin
         active_ff[cur_slot_ff] <= 1'b1;
      end else if (ctl.clr_act) begin
         active_ff[cur_slot_ff] <= 1'b0;
      end
   end

   assign id_ok = (32'(req_ff.timer_id) < 32'(TIMER_SLOTS));
   assign act   = active_ff[cur_slot_ff];

   always_comb begin
      sts.cmd      = req_ff.command;
      sts.is_tick  = (req_ff.command == CMD_TICK);
      sts.head_due = cell_vld_ff[0] && cell_due_ff[0];
      sts.next_due = cell_vld_ff[1] && cell_due_ff[1];
      sts.periodic = (rd_kind_ff == KIND_PERIODIC);
      unique case (req_ff.command)
         CMD_ADD: sts.err = !id_ok || act || (req_ff.timer_kind == 2'd3)
                            || (req_ff.time_value == '0);
         CMD_DELETE: sts.err = !id_ok || !act;
         CMD_CHANGE: sts.err = !id_ok || !act || req_ff.timer_kind[1]
                               || (rd_kind_ff == KIND_PERIODIC)
                               || (req_ff.time_value == '0);
         default: sts.err = 1'b0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         goes[i]  = !cell_vld_ff[i] || (exp_ff < cell_exp_ff[i]);
         match[i] = cell_vld_ff[i] && (cell_slot_ff[i] == cur_slot_ff);
      end
      after[0] = match[0];
      for (int i = 1; i < TIMER_SLOTS; i++) begin
         after[i] = after[i-1] | match[i];
      end
   end

   always_comb begin
      int p;
      int n;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         p = (i == 0) ? 0 : i - 1;
         n = (i == TIMER_SLOTS - 1) ? i : i + 1;
         cell_slot_in[i] = cell_slot_ff[i];
         cell_exp_in[i]  = cell_exp_ff[i];
         cell_vld_in[i]  = cell_vld_ff[i];
         cell_due_in[i]  = cell_due_ff[i];
         if (ctl.insert) begin
            if (goes[i] && (i > 0) && goes[p]) begin
               cell_slot_in[i] = cell_slot_ff[p];
               cell_exp_in[i]  = cell_exp_ff[p];
               cell_vld_in[i]  = cell_vld_ff[p];
               cell_due_in[i]  = cell_due_ff[p];
            end else if (goes[i]) begin
               cell_slot_in[i] = cur_slot_ff;
               cell_exp_in[i]  = exp_ff;
               cell_vld_in[i]  = 1'b1;
               cell_due_in[i]  = 1'b0;
            end
         end else if ((ctl.remove && after[i]) || ctl.pop) begin
            cell_slot_in[i] = cell_slot_ff[n];
            cell_exp_in[i]  = cell_exp_ff[n];
            cell_vld_in[i]  = (i == TIMER_SLOTS - 1) ? 1'b0 : cell_vld_ff[n];
            cell_due_in[i]  = cell_due_ff[n];
         end else if (ctl.mark) begin
            cell_due_in[i] = cell_vld_ff[i] && !(req_ff.now < cell_exp_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= '0;
      end else begin
         cell_vld_ff <= cell_vld_in;
      end
      cell_due_ff  <= cell_due_in;
      cell_slot_ff <= cell_slot_in;
      cell_exp_ff  <= cell_exp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.emit;
      end
      if (ctl.emit) begin
         rsp_item_ff.event_kind <= ctl.emit_kind;
         rsp_item_ff.retired    <= ctl.emit_retired;
         rsp_item_ff.last       <= ctl.emit_last;
         priority case (ctl.emit_kind)
            EV_EXPIRED: rsp_item_ff.event_timer <= cur_ext[ID_BITS-1:0];
            EV_NONE:    rsp_item_ff.event_timer <= '0;
            default:    rsp_item_ff.event_timer <= req_ff.timer_id;
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |-> !cell_vld_ff[TIMER_SLOTS-1])
      else $error("insert into full list");
   a_pop_due: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> cell_vld_ff[0] && cell_due_ff[0])
      else $error("pop of head that is not due");
   a_remove_one: assert property (@(posedge clock) disable iff (reset)
      ctl.remove |-> $countones(match) == 1)
      else $error("remove without a single matching cell");
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      cell_vld_ff[1] |-> cell_vld_ff[0])
      else $error("list has a hole");

endmodule

/* hw/rtl/stq_controller.sv */
// ---------------------------------------------------------------------------
// Sorted timer queue controller
// Command sequencing for add, delete, change and tick.
// ---------------------------------------------------------------------------
module stq_controller import stq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output logic    busy,
   output ctl_type ctl
);

   state_type state_ff;
   state_type state_in;
   logic      first_ff;
   logic      first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      ctl      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.is_tick) begin
               ctl.mark = 1'b1;
               first_in = 1'b1;
               state_in = ST_TICK_HEAD;
            end else if (sts.err) begin
               ctl.emit      = 1'b1;
               ctl.emit_kind = EV_ERROR;
               ctl.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end else if (sts.cmd == CMD_DELETE) begin
               ctl.remove    = 1'b1;
               ctl.clr_act   = 1'b1;
               ctl.emit      = 1'b1;
               ctl.emit_kind = EV_ACK;
               ctl.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ctl.remove   = (sts.cmd == CMD_CHANGE);
               ctl.set_act  = (sts.cmd == CMD_ADD);
               ctl.mem_wr   = 1'b1;
               ctl.load_req = 1'b1;
               state_in     = ST_INSERT;
            end
         end
         ST_INSERT: begin
            ctl.insert = 1'b1;
            if (sts.is_tick) begin
               state_in = ST_TICK_HEAD;
            end else begin
               ctl.emit      = 1'b1;
               ctl.emit_kind = EV_ACK;
               ctl.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_TICK_HEAD: begin
            if (sts.head_due) begin
               ctl.head_sel = 1'b1;
               first_in     = 1'b0;
               state_in     = ST_TICK_POP;
            end else begin
               ctl.emit      = first_ff;
               ctl.emit_kind = EV_NONE;
               ctl.emit_last = 1'b1;
               first_in      = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_TICK_POP: begin
            ctl.pop          = 1'b1;
            ctl.emit         = 1'b1;
            ctl.emit_kind    = EV_EXPIRED;
            ctl.emit_retired = !sts.periodic;
            ctl.emit_last    = !sts.next_due;
            if (sts.periodic) begin
               ctl.load_per = 1'b1;
               state_in     = ST_INSERT;
            end else begin
               ctl.clr_act = 1'b1;
               state_in    = ST_TICK_HEAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $countones({ctl.insert, ctl.pop, ctl.mark, ctl.remove}) <= 1)
      else $error("conflicting list updates");
   a_latch_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.latch |=> state_ff == ST_CHECK)
      else $error("accepted item not checked");
   a_per_insert: assert property (@(posedge clock) disable iff (reset)
      ctl.load_per |=> ctl.insert)
      else $error("periodic timer not re-queued");

endmodule

/* hw/rtl/sorted_timer_queue.sv */
// ---------------------------------------------------------------------------
// Sorted timer queue
// Keeps timers in a list sorted by expiry, oldest first among equal expiries.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Add, delete and change
// give one result each; a tick gives one result per expired timer (a periodic
// one is re-queued) or a none result if no timer is due. A slot table read
// precedes each expiry, and the list takes a single update per cycle. Results
// appear for one cycle on rsp_strobe and cannot be held off; busy drops once
// the last is issued.
module sorted_timer_queue import stq_pkg::*; #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   ctl_type ctl;
   sts_type sts;

   stq_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .ctl   (ctl)
   );

   stq_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
